[src/sts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sphere triangle subdivider.
// ----------------------------------------------------------------------------
package sts_pkg;
  localparam int CoordW = 16;
  localparam int FracBits = 14;
  localparam int MaxDepth = 3;
  localparam int SumW = CoordW + 1;
  localparam int NormW = 2 * SumW + 2;
  localparam int QW = FracBits + 1;
  localparam int AccW = NormW + 2 * QW + 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MID_START,
    ST_MID_WAIT,
    ST_DESCEND,
    ST_EMIT,
    ST_ASCEND,
    ST_NEXT
  } state_t;

  typedef struct packed {
    logic load;
    logic mid_start;
    logic [1:0] mid_sel;
    logic push_row;
    logic pick_child;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic mid_done;
    logic [1:0] mid_cnt;
  } stat_t;
endpackage
`default_nettype wire

[src/sphere_triangle_subdivider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// Recursively splits a spherical triangle into 4^depth leaf triangles.
// ----------------------------------------------------------------------------
// Usage: a base triangle arrives as one transaction on s_axis (three
// corners, x/y/z each, signed Q1.14). The block emits 4^D leaf triangles on
// m_axis, depth first, with tlast on the final leaf. D comes from the cfg
// channel (reset 3), sampled when a base triangle is accepted; write it only
// while idle.
// Each midpoint passes through the shared normalizer (start, three
// squares, then a setup step and one quotient bit per cycle for each
// component), three per inner node. At depth 3 a base triangle has 21
// inner nodes and 64 leaves. The normalizer is the limit on rate.
// Reset returns to idle with depth 3. When m_axis stalls, the leaf stays in
// the output register and the next leaf waits to be emitted; s_axis_tready
// stays low until the whole base triangle has been delivered.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  input  wire [143:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // leaf a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire [1:0]    cfg_data
);
  sts_pkg::cmd_t cmd;
  sts_pkg::stat_t stat;
  logic [1:0] depth, level, child;
  logic emit_last, in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= 2'd3;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) depth <= cfg_data;
      if (cmd.emit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  sts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .depth(depth), .stat(stat),
    .out_busy(m_axis_tvalid && !m_axis_tready), .in_ready(s_axis_tready),
    .emit_last(emit_last), .cmd(cmd), .level(level), .child(child)
  );

  sts_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .level(level), .child(child),
    .in_data(s_axis_tdata), .last(emit_last), .stat(stat),
    .out_data(m_axis_tdata), .out_last(m_axis_tlast)
  );

  a_no_in_when_out: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !in_fire) else $error("input accepted during emit");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_axis_tvalid) else $error("emit lost");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    level <= 2'd3) else $error("level out of range");
endmodule
`default_nettype wire

[src/sts_norm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_norm
// Normalizes the sum of two vectors, one component at a time and one quotient bit
// per cycle, with an exact rounding test against the squared length that
// is kept up to date by shifts and adds.
// ----------------------------------------------------------------------------
module sts_norm (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  sts_pkg::vec_t       p,
  input  sts_pkg::vec_t       q,
  output logic                done,
  output sts_pkg::vec_t       res
);
  typedef enum logic [2:0] {N_IDLE, N_SQ, N_BIT, N_NEXT} nstate_t;

  nstate_t st;
  logic signed [sts_pkg::SumW-1:0] s [3];
  logic [sts_pkg::NormW-1:0] n;
  logic [1:0] comp;
  logic [1:0] sq;
  logic [3:0] bitn;
  logic [sts_pkg::QW-1:0] qv;
  logic [sts_pkg::SumW-1:0] amag;
  logic [2*sts_pkg::SumW-1:0] a2;
  logic [sts_pkg::QW:0] trial;
  logic [sts_pkg::AccW-1:0] lacc;
  logic signed [sts_pkg::AccW-1:0] ms;
  logic [sts_pkg::AccW-1:0] ns;
  logic [sts_pkg::AccW-1:0] lt;
  logic [sts_pkg::AccW-1:0] ms_add;
  logic ok;
  logic [2*sts_pkg::SumW+2*sts_pkg::FracBits+1:0] rhs;
  logic [sts_pkg::SumW-1:0] sqin;
  logic [sts_pkg::QW-1:0] kmax;

  assign kmax = sts_pkg::QW'(1) << sts_pkg::FracBits;
  assign sqin = s[sq][sts_pkg::SumW-1] ? sts_pkg::SumW'(-s[sq]) : sts_pkg::SumW'(s[sq]);
  assign amag = s[comp][sts_pkg::SumW-1] ? sts_pkg::SumW'(-s[comp]) : sts_pkg::SumW'(s[comp]);
  assign trial = {1'b0, qv} | ((sts_pkg::QW+1)'(1) << bitn);
  assign lt = lacc + $unsigned(ms) + ns;
  assign rhs = {a2, 2'b00} << (2 * sts_pkg::FracBits);
  assign ok = trial <= (sts_pkg::QW+1)'(kmax) && lt <= sts_pkg::AccW'(rhs);
  assign ms_add = ok ? ns : '0;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st <= N_IDLE;
    end else begin
      unique case (st)
        N_IDLE: begin
          if (start) begin
            s[0] <= sts_pkg::SumW'(p.x) + sts_pkg::SumW'(q.x);
            s[1] <= sts_pkg::SumW'(p.y) + sts_pkg::SumW'(q.y);
            s[2] <= sts_pkg::SumW'(p.z) + sts_pkg::SumW'(q.z);
            n <= '0;
            sq <= 2'd0;
            comp <= 2'd0;
            st <= N_SQ;
          end
        end
        N_SQ: begin
          n <= n + sts_pkg::NormW'(sqin * sqin);
          if (sq == 2'd2) begin
            st <= N_NEXT;
            comp <= 2'd0;
          end
          sq <= sq + 2'd1;
        end
        N_NEXT: begin
          a2 <= amag * amag;
          qv <= '0;
          bitn <= 4'(sts_pkg::FracBits);
          lacc <= sts_pkg::AccW'(n);
          ms <= $signed(sts_pkg::AccW'(0) - (sts_pkg::AccW'(n) << (sts_pkg::FracBits + 2)));
          ns <= sts_pkg::AccW'(n) << (2 * sts_pkg::FracBits + 2);
          st <= N_BIT;
        end
        N_BIT: begin
          if (ok) begin
            qv <= trial[sts_pkg::QW-1:0];
            lacc <= lt;
          end
          ms <= (ms >>> 1) + $signed(ms_add);
          ns <= ns >> 2;
          if (bitn == 4'd0) begin
            if (n == '0 || amag == '0) res[16*comp +: 16] <= '0;
            else if (s[comp][sts_pkg::SumW-1])
              res[16*comp +: 16] <= -sts_pkg::CoordW'(ok ? trial[sts_pkg::QW-1:0] : qv);
            else
              res[16*comp +: 16] <= sts_pkg::CoordW'(ok ? trial[sts_pkg::QW-1:0] : qv);
            if (comp == 2'd2) begin
              st <= N_IDLE;
              done <= 1'b1;
            end else begin
              comp <= comp + 2'd1;
              st <= N_NEXT;
            end
          end else begin
            bitn <= bitn - 4'd1;
          end
        end
        default: st <= N_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/sts_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_datapath
// Holds the current triangle, the per-level vertex stack and the output
// register, and drives the midpoint normalizer.
// ----------------------------------------------------------------------------
module sts_datapath (
  input  wire             clk,
  input  wire             rst,
  input  sts_pkg::cmd_t   cmd,
  input  wire [1:0]       level,
  input  wire [1:0]       child,
  input  wire [143:0]     in_data,
  input  wire             last,
  output sts_pkg::stat_t  stat,
  output logic [143:0]    out_data,
  output logic            out_last
);
  sts_pkg::vec_t cur [3];
  sts_pkg::vec_t stack [sts_pkg::MaxDepth*6];
  sts_pkg::vec_t np, nq, nres;
  logic ndone;
  logic [1:0] mcnt;
  logic [4:0] base;
  logic [2:0] pk [3];

  assign base = 5'(level) * 5'd6;

  always_comb begin
    unique case (cmd.mid_sel)
      2'd0: begin np = cur[0]; nq = cur[1]; end
      2'd1: begin np = cur[1]; nq = cur[2]; end
      default: begin np = cur[2]; nq = cur[0]; end
    endcase
    unique case (child)
      2'd0: begin pk[0] = 3'd3; pk[1] = 3'd4; pk[2] = 3'd5; end
      2'd1: begin pk[0] = 3'd0; pk[1] = 3'd3; pk[2] = 3'd5; end
      2'd2: begin pk[0] = 3'd1; pk[1] = 3'd4; pk[2] = 3'd3; end
      default: begin pk[0] = 3'd2; pk[1] = 3'd5; pk[2] = 3'd4; end
    endcase
  end

  sts_norm u_norm (
    .clk(clk), .rst(rst), .start(cmd.mid_start), .p(np), .q(nq),
    .done(ndone), .res(nres)
  );

  assign stat.mid_done = ndone;
  assign stat.mid_cnt = mcnt;

  always_ff @(posedge clk) begin
    if (rst) mcnt <= 2'd0;
    else if (cmd.push_row) mcnt <= 2'd0;
    else if (ndone) mcnt <= mcnt + 2'd1;
    if (cmd.load) begin
      cur[0] <= in_data[47:0];
      cur[1] <= in_data[95:48];
      cur[2] <= in_data[143:96];
    end
    if (ndone) stack[base + 5'd3 + 5'(mcnt)] <= nres;
    if (cmd.push_row) begin
      stack[base] <= cur[0];
      stack[base + 5'd1] <= cur[1];
      stack[base + 5'd2] <= cur[2];
    end
    if (cmd.pick_child) begin
      cur[0] <= stack[base + 5'(pk[0])];
      cur[1] <= stack[base + 5'(pk[1])];
      cur[2] <= stack[base + 5'(pk[2])];
    end
    if (cmd.emit) begin
      out_data <= {cur[2], cur[1], cur[0]};
      out_last <= last;
    end
  end
endmodule
`default_nettype wire

[src/sts_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ctrl
// Depth-first traversal controller for the subdivision tree.
// ----------------------------------------------------------------------------
module sts_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_fire,
  input  wire [1:0]       depth,
  input  sts_pkg::stat_t  stat,
  input  wire             out_busy,
  output logic            in_ready,
  output logic            emit_last,
  output sts_pkg::cmd_t   cmd,
  output logic [1:0]      level,
  output logic [1:0]      child
);
  sts_pkg::state_t state, state_next;
  logic [1:0] lvl, lvl_next;
  logic [1:0] cpos [3];
  logic [1:0] dep;
  logic [6:0] cnt;
  logic [6:0] total;

  assign total = 7'd1 << (2 * dep);
  assign emit_last = (cnt + 7'd1 == total);
  assign level = lvl;

  always_comb begin
    state_next = state;
    unique case (state)
      sts_pkg::ST_IDLE: if (in_fire) state_next = sts_pkg::ST_LOAD;
      sts_pkg::ST_LOAD: state_next = (lvl < dep) ? sts_pkg::ST_MID_START : sts_pkg::ST_EMIT;
      sts_pkg::ST_MID_START: state_next = sts_pkg::ST_MID_WAIT;
      sts_pkg::ST_MID_WAIT:
        if (stat.mid_done)
          state_next = (stat.mid_cnt == 2'd2) ? sts_pkg::ST_DESCEND : sts_pkg::ST_MID_START;
      sts_pkg::ST_DESCEND: state_next = sts_pkg::ST_LOAD;
      sts_pkg::ST_EMIT:
        if (!out_busy) state_next = emit_last ? sts_pkg::ST_IDLE : sts_pkg::ST_ASCEND;
      sts_pkg::ST_ASCEND: if (cpos[lvl - 2'd1] != 2'd3) state_next = sts_pkg::ST_NEXT;
      sts_pkg::ST_NEXT: state_next = sts_pkg::ST_LOAD;
      default: state_next = sts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == sts_pkg::ST_IDLE) && !out_busy;
    cmd.load = in_fire;
    cmd.mid_sel = stat.mid_cnt;
    child = cpos[lvl];
    lvl_next = lvl;
    unique case (state)
      sts_pkg::ST_LOAD: cmd.push_row = (lvl < dep);
      sts_pkg::ST_MID_START: cmd.mid_start = 1'b1;
      sts_pkg::ST_DESCEND: begin
        cmd.pick_child = 1'b1;
        child = 2'd0;
      end
      sts_pkg::ST_EMIT: cmd.emit = !out_busy;
      sts_pkg::ST_ASCEND: lvl_next = lvl - 2'd1;
      sts_pkg::ST_NEXT: begin
        cmd.pick_child = 1'b1;
        child = cpos[lvl];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sts_pkg::ST_IDLE;
      lvl <= 2'd0;
      cnt <= 7'd0;
      dep <= 2'd0;
      for (int i = 0; i < 3; i++) cpos[i] <= 2'd0;
    end else begin
      state <= state_next;
      unique case (state)
        sts_pkg::ST_IDLE: if (in_fire) begin
          lvl <= 2'd0;
          cnt <= 7'd0;
          dep <= depth;
        end
        sts_pkg::ST_DESCEND: begin
          cpos[lvl] <= 2'd0;
          lvl <= lvl + 2'd1;
        end
        sts_pkg::ST_EMIT: if (!out_busy) cnt <= cnt + 7'd1;
        sts_pkg::ST_ASCEND: if (cpos[lvl - 2'd1] != 2'd3) begin
          cpos[lvl - 2'd1] <= cpos[lvl - 2'd1] + 2'd1;
          lvl <= lvl_next;
        end else lvl <= lvl_next;
        sts_pkg::ST_NEXT: lvl <= lvl + 2'd1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
